/* hdl/sfr_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the serial frame receiver.
// No dependencies; imported by every module of the block.
package sfr_pkg;

  localparam logic [7:0]  HDR_BYTE       = 8'hFE;
  localparam logic [7:0]  FTR_BYTE       = 8'hFF;
  localparam logic [7:0]  CRC_POLY       = 8'h31;
  localparam logic [7:0]  CRC_INIT       = 8'hFF;
  localparam logic [15:0] FRAME_OVERHEAD = 16'd9;
  localparam logic [15:0] CNT_MAX        = 16'hFFFF;
  localparam logic [15:0] CNT_HDR        = 16'd1;
  localparam logic [15:0] CNT_SIZE_HI    = 16'd3;
  localparam logic [15:0] CNT_ELEM_HI    = 16'd6;

  localparam int TDATA_W = 88;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SEQ    = 3'd1,
    PH_SIZE   = 3'd2,
    PH_CMD    = 3'd3,
    PH_ELEM   = 3'd4,
    PH_DATA   = 3'd5,
    PH_CRC    = 3'd6,
    PH_FOOTER = 3'd7
  } phase_t;

  typedef struct packed {
    logic        is_end;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  sequence_number;
    logic [7:0]  command_code;
    logic [15:0] element_number;
    logic [15:0] payload_length;
    logic [7:0]  received_check;
    logic        check_ok;
    logic        length_ok;
  } sfr_result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/sfr_deframer.sv */
// Frame parser: phase state machine, frame fields, running CRC and byte count.
// Depends on sfr_pkg. Produces at most one result per byte, combinationally.
module sfr_deframer
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  output sfr_result_t res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] declared_size_r, declared_size_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] elem_r, elem_nxt;
  logic [15:0] payload_left_r, payload_left_nxt;
  logic [15:0] pay_idx_r, pay_idx_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] frame_bytes_r, frame_bytes_nxt;
  logic [7:0]  crc_byte_r, crc_byte_nxt;

  logic [15:0] fb_inc;
  logic [15:0] plen;
  logic [7:0]  crc_upd;

  assign fb_inc  = (frame_bytes_r != CNT_MAX) ? frame_bytes_r + 16'd1 : frame_bytes_r;
  assign plen    = (declared_size_r >= FRAME_OVERHEAD) ? declared_size_r - FRAME_OVERHEAD
                                                      : 16'd0;
  assign crc_upd = crc8_update(crc_r, rx_byte);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HEADER: if (rx_byte == HDR_BYTE) phase_nxt = PH_SEQ;
      PH_SEQ:    phase_nxt = PH_SIZE;
      PH_SIZE:   if (fb_inc != CNT_SIZE_HI) phase_nxt = PH_CMD;
      PH_CMD:    phase_nxt = PH_ELEM;
      PH_ELEM:   if (fb_inc != CNT_ELEM_HI) phase_nxt = (plen != 16'd0) ? PH_DATA : PH_CRC;
      PH_DATA:   if (payload_left_r == 16'd1) phase_nxt = PH_CRC;
      PH_CRC:    phase_nxt = PH_FOOTER;
      PH_FOOTER: if (rx_byte == FTR_BYTE) phase_nxt = PH_HEADER;
      default:   phase_nxt = PH_HEADER;
    endcase
  end

  always_comb begin
    seq_nxt           = seq_r;
    declared_size_nxt = declared_size_r;
    cmd_nxt           = cmd_r;
    elem_nxt          = elem_r;
    payload_left_nxt  = payload_left_r;
    pay_idx_nxt       = pay_idx_r;
    crc_nxt           = crc_r;
    frame_bytes_nxt   = (phase_r == PH_HEADER) ? frame_bytes_r : fb_inc;
    crc_byte_nxt      = crc_byte_r;
    res_valid         = 1'b0;

    res.is_end          = 1'b0;
    res.payload_byte    = 8'd0;
    res.payload_index   = 16'd0;
    res.sequence_number = seq_r;
    res.command_code    = cmd_r;
    res.element_number  = elem_r;
    res.payload_length  = plen;
    res.received_check  = 8'd0;
    res.check_ok        = 1'b0;
    res.length_ok       = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        if (rx_byte == HDR_BYTE) begin
          seq_nxt           = 8'd0;
          declared_size_nxt = 16'd0;
          cmd_nxt           = 8'd0;
          elem_nxt          = 16'd0;
          payload_left_nxt  = 16'd0;
          pay_idx_nxt       = 16'd0;
          crc_nxt           = CRC_INIT;
          frame_bytes_nxt   = CNT_HDR;
          crc_byte_nxt      = 8'd0;
        end
      end
      PH_SEQ: seq_nxt = rx_byte;
      PH_SIZE: begin
        if (fb_inc == CNT_SIZE_HI) begin
          declared_size_nxt = {rx_byte, 8'd0};
        end else begin
          declared_size_nxt = {declared_size_r[15:8], rx_byte};
          crc_nxt           = crc_upd;
        end
      end
      PH_CMD: begin
        cmd_nxt = rx_byte;
        crc_nxt = crc_upd;
      end
      PH_ELEM: begin
        crc_nxt = crc_upd;
        if (fb_inc == CNT_ELEM_HI) begin
          elem_nxt = {rx_byte, 8'd0};
        end else begin
          elem_nxt         = {elem_r[15:8], rx_byte};
          payload_left_nxt = plen;
          pay_idx_nxt      = 16'd0;
        end
      end
      PH_DATA: begin
        crc_nxt           = crc_upd;
        payload_left_nxt  = payload_left_r - 16'd1;
        pay_idx_nxt       = pay_idx_r + 16'd1;
        res_valid         = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = pay_idx_r;
      end
      PH_CRC: crc_byte_nxt = rx_byte;
      PH_FOOTER: begin
        if (rx_byte == FTR_BYTE) begin
          res_valid          = 1'b1;
          res.is_end         = 1'b1;
          res.received_check = crc_byte_r;
          res.check_ok       = (crc_r == crc_byte_r);
          res.length_ok      = (declared_size_r >= FRAME_OVERHEAD) &&
                               (fb_inc == declared_size_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      seq_r           <= 8'd0;
      declared_size_r <= 16'd0;
      cmd_r           <= 8'd0;
      elem_r          <= 16'd0;
      payload_left_r  <= 16'd0;
      pay_idx_r       <= 16'd0;
      crc_r           <= CRC_INIT;
      frame_bytes_r   <= 16'd0;
      crc_byte_r      <= 8'd0;
    end else if (fire) begin
      phase_r         <= phase_nxt;
      seq_r           <= seq_nxt;
      declared_size_r <= declared_size_nxt;
      cmd_r           <= cmd_nxt;
      elem_r          <= elem_nxt;
      payload_left_r  <= payload_left_nxt;
      pay_idx_r       <= pay_idx_nxt;
      crc_r           <= crc_nxt;
      frame_bytes_r   <= frame_bytes_nxt;
      crc_byte_r      <= crc_byte_nxt;
    end
  end

`ifndef SYNTH
  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> payload_left_r != 16'd0)
    else $error("payload phase with nothing left");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_HEADER |-> frame_bytes_r != 16'd0)
    else $error("frame byte count zero inside frame");

  a_hdr_start: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == PH_HEADER && rx_byte == HDR_BYTE
    |=> phase_r == PH_SEQ && frame_bytes_r == CNT_HDR && crc_r == CRC_INIT)
    else $error("header did not start a frame");
`endif

endmodule

/* hdl/sfr_out_stage.sv */
// Result register between the parser and the output stream.
// Depends on sfr_pkg; holds one result until the consumer takes it.
module sfr_out_stage
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  sfr_result_t res,
  input  logic        take,
  output logic        space,
  output logic        valid,
  output sfr_result_t data
);

  logic        valid_r, valid_nxt;
  sfr_result_t data_r;

  assign space = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

`ifndef SYNTH
  a_load_space: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> space)
    else $error("result loaded over an untaken result");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded result not presented");

  a_idle_drop: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && take && !load |=> !valid_r)
    else $error("taken result not dropped");
`endif

endmodule

/* hdl/serial_frame_receiver_crc8_top.sv */
// Serial frame receiver top: input register, frame parser and result register.
// Depends on sfr_pkg, sfr_deframer and sfr_out_stage.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata[7:0] rx_byte
//  out_    | out | out_tvalid/out_tready| out_tdata, out_tuser is_end, out_tlast last
//
// One byte per cycle sustained while the output does not stall; a byte is held in
// the input register until it is parsed, and its result is presented from the next edge on.
// Throughput is set by the combinational CRC-8 byte update in the parser.
// Synchronous active-low reset returns the parser to header search.
// A stalled output blocks only bytes that produce a result; others pass.
module serial_frame_receiver_crc8_top
  import sfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] rx_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  // [7:0] payload_byte, [23:8] payload_index, [31:24] sequence_number,
  // [39:32] command_code, [55:40] element_number, [71:56] payload_length,
  // [79:72] received_check, [80] check_ok, [81] length_ok, [87:82] zero
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tuser,  // [0] is_end
  output logic               out_tlast
);

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r;
  logic        res_valid;
  sfr_result_t res;
  logic        space;
  logic        advance;
  logic        load;
  sfr_result_t out_res;

  assign advance   = in_valid_r && (!res_valid || space);
  assign load      = advance && res_valid;
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  sfr_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  sfr_out_stage u_out_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .res   (res),
    .take  (out_tready),
    .space (space),
    .valid (out_tvalid),
    .data  (out_res)
  );

  assign out_tdata = {6'd0,
                      out_res.length_ok,
                      out_res.check_ok,
                      out_res.received_check,
                      out_res.payload_length,
                      out_res.element_number,
                      out_res.command_code,
                      out_res.sequence_number,
                      out_res.payload_index,
                      out_res.payload_byte};
  assign out_tuser = out_res.is_end;
  assign out_tlast = out_res.is_end;

`ifndef SYNTH
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_byte_r))
    else $error("held input byte lost");

  a_pay_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[81:72] == 10'd0)
    else $error("payload result carries summary fields");

  a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[23:0] == 24'd0)
    else $error("summary carries payload fields");
`endif

endmodule
